### design/cdds_pkg.sv
`timescale 1ns / 1ps

package cdds_pkg;

  localparam int unsigned ValW  = 7;
  localparam int unsigned DigW  = 4;
  localparam int unsigned SegW  = 8;
  localparam int unsigned PosW  = 2;

  localparam logic [SegW-1:0] SEG_BLANK   = 8'hFF;
  localparam logic [3:0]      HOUR_TENS_MAX   = 4'd2;
  localparam logic [3:0]      MINUTE_TENS_MAX = 4'd6;
  localparam logic [3:0]      UNITS_MAX       = 4'd9;

  // reciprocal of ten, exact for values below 1029
  localparam logic [7:0]  DIV10_MUL   = 8'd205;
  localparam int unsigned DIV10_SHIFT = 11;

  typedef enum logic [PosW-1:0] {
    POS_HOUR_TENS    = 2'd0,
    POS_HOUR_UNITS   = 2'd1,
    POS_MINUTE_TENS  = 2'd2,
    POS_MINUTE_UNITS = 2'd3
  } digit_pos_t;

  typedef struct packed {
    logic [ValW-1:0] hour_value;
    logic [ValW-1:0] minute_value;
  } in_item_t;

  typedef struct packed {
    logic [DigW-1:0] digit_enable;
    logic [SegW-1:0] segment_bits;
  } out_item_t;

  function automatic logic [SegW-1:0] digit_pattern(input logic [3:0] d);
    logic [SegW-1:0] p;
    case (d)
      4'd0: p = 8'hC0;
      4'd1: p = 8'hF9;
      4'd2: p = 8'hA4;
      4'd3: p = 8'hB0;
      4'd4: p = 8'h99;
      4'd5: p = 8'h92;
      4'd6: p = 8'h82;
      4'd7: p = 8'hF8;
      4'd8: p = 8'h80;
      4'd9: p = 8'h90;
      default: p = SEG_BLANK;
    endcase
    return p;
  endfunction

endpackage

### design/clock_display_digit_scanner.sv
`timescale 1ns / 1ps

// an accepted request is registered into the result register, or into the skid entry while a result waits
// throughput: one request per cycle while out_stall stays low
// a two-entry output buffer (result register plus skid) keeps the input open
// for one more request while a result waits; in_stall is registered
// reset (synchronous, rst_n low) empties the buffer and points at hour tens
module clock_display_digit_scanner
  import cdds_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  digit_pos_t pos_r, pos_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  out_item_t  out_r, out_nxt;
  out_item_t  skid_r, skid_nxt;

  logic       in_fire, out_fire;
  logic [6:0] sel_val;
  logic [14:0] prod;
  logic [3:0] tens, units, digit, digit_max;
  logic [SegW-1:0] seg;
  out_item_t  result;

  assign in_fire  = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;

  // decode the digit selected by the pointer
  always_comb begin
    if (pos_r == POS_HOUR_TENS || pos_r == POS_HOUR_UNITS) begin
      sel_val = in_data.hour_value;
    end else begin
      sel_val = in_data.minute_value;
    end
    prod  = {8'd0, sel_val} * {7'd0, DIV10_MUL};
    tens  = prod[DIV10_SHIFT+3:DIV10_SHIFT];
    units = 4'(sel_val - 7'(tens) * 7'd10);
    case (pos_r)
      POS_HOUR_TENS: begin
        digit     = tens;
        digit_max = HOUR_TENS_MAX;
      end
      POS_MINUTE_TENS: begin
        digit     = tens;
        digit_max = MINUTE_TENS_MAX;
      end
      default: begin
        digit     = units;
        digit_max = UNITS_MAX;
      end
    endcase
    if (digit > digit_max) begin
      seg = SEG_BLANK;
    end else begin
      seg = digit_pattern(digit);
    end
    // dot lit on hour units
    if (pos_r == POS_HOUR_UNITS) begin
      seg[SegW-1] = 1'b0;
    end
    result.digit_enable = DigW'(1) << pos_r;
    result.segment_bits = seg;
  end

  always_comb begin
    pos_nxt        = pos_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (in_fire) begin
      pos_nxt = digit_pos_t'(pos_r + 2'd1);
    end
    if (skid_valid_r) begin
      if (out_fire) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_nxt       = result;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = result;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= POS_HOUR_TENS;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_onehot_enable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot(out_r.digit_enable))
    else $error("digit enable not one-hot");

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty result register");

  a_pointer_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pos_r == digit_pos_t'($past(pos_r) + 2'd1))
    else $error("digit pointer did not advance");

  a_dot_only_hour_units: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.digit_enable[POS_HOUR_UNITS]) |-> out_r.segment_bits[SegW-1])
    else $error("dot lit outside hour units");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> !skid_valid_r)
    else $error("skid entry not moved on a free output");

endmodule
